[hdl/s256re_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 round engine package
// Shared widths, the request code type and the SHA-256 sigma functions.
// ----------------------------------------------------------------------------
package s256re_pkg;

    // Word and storage sizes.
    localparam int WORD_W      = 32;
    localparam int CHAIN_DEPTH = 4;
    localparam int WIN_DEPTH   = 16;

    // Rotation and shift amounts of the message schedule functions.
    localparam int SS0_R1 = 7;
    localparam int SS0_R2 = 18;
    localparam int SS0_SH = 3;
    localparam int SS1_R1 = 17;
    localparam int SS1_R2 = 19;
    localparam int SS1_SH = 10;

    // Rotation amounts of the compression functions.
    localparam int BS0_R1 = 2;
    localparam int BS0_R2 = 13;
    localparam int BS0_R3 = 22;
    localparam int BS1_R1 = 6;
    localparam int BS1_R2 = 11;
    localparam int BS1_R3 = 25;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [CHAIN_DEPTH-1:0] chain_t;
    typedef word_t [WIN_DEPTH-1:0] window_t;

    // Request codes carried in each input beat.
    typedef enum logic [1:0] {
        REQ_INIT   = 2'd0,
        REQ_LOAD   = 2'd1,
        REQ_MIX    = 2'd2,
        REQ_FINISH = 2'd3
    } req_type_t;

    // Rotate right by a constant amount.
    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = rotr(x, SS0_R1) ^ rotr(x, SS0_R2) ^ (x >> SS0_SH);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = rotr(x, SS1_R1) ^ rotr(x, SS1_R2) ^ (x >> SS1_SH);
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = rotr(x, BS0_R1) ^ rotr(x, BS0_R2) ^ rotr(x, BS0_R3);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = rotr(x, BS1_R1) ^ rotr(x, BS1_R2) ^ rotr(x, BS1_R3);
    endfunction

endpackage

[hdl/s256re_in_if.sv]
// ----------------------------------------------------------------------------
// SHA-256 round engine request channel
// Valid/ready channel that carries one request beat.
// ----------------------------------------------------------------------------
interface s256re_in_if
    import s256re_pkg::*;
();
    logic      valid;
    logic      ready;
    req_type_t req_type;
    word_t     word_a;
    word_t     word_e;
    word_t     round_const;
    logic      continue_chain;

    modport source (
        output valid, req_type, word_a, word_e, round_const, continue_chain,
        input  ready
    );

    modport sink (
        input  valid, req_type, word_a, word_e, round_const, continue_chain,
        output ready
    );
endinterface

[hdl/s256re_out_if.sv]
// ----------------------------------------------------------------------------
// SHA-256 round engine result channel
// Valid/ready channel that carries one result beat.
// ----------------------------------------------------------------------------
interface s256re_out_if
    import s256re_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t a_new;
    word_t e_new;
    word_t w_new;

    modport source (
        output valid, a_new, e_new, w_new,
        input  ready
    );

    modport sink (
        input  valid, a_new, e_new, w_new,
        output ready
    );
endinterface

[hdl/sha256_round_engine_top.sv]
// ----------------------------------------------------------------------------
// SHA-256 round engine
// One typed request per beat: init, load round, mix round or finish.
// ----------------------------------------------------------------------------
// Each request passes through an input register and then the combinational
// round logic, which updates the a/e chains (and the saved start words on
// init and finish, the 16-word schedule window on load and mix) and writes
// the result register. The engine accepts one request per clock while the
// result channel is ready and returns exactly one result beat per request.
// The throughput limit is the combinational round datapath: schedule sum
// followed by the round additions. Backpressure on the result channel holds
// the input register, so at most two requests are in the engine at once.
module sha256_round_engine_top
    import s256re_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    s256re_in_if.sink         in_ch,
    s256re_out_if.source      out_ch
);

    // Input register.
    logic      in_valid_reg;
    req_type_t req_reg;
    word_t     word_a_reg;
    word_t     word_e_reg;
    word_t     k_reg;
    logic      cont_reg;

    // Engine state.
    chain_t    a_chain_reg;
    chain_t    e_chain_reg;
    chain_t    a_start_reg;
    chain_t    e_start_reg;
    window_t   w_window_reg;

    // Result register.
    logic      out_valid_reg;
    word_t     a_out_reg;
    word_t     e_out_reg;
    word_t     w_out_reg;

    logic      advance;
    word_t     sched_w;
    word_t     round_w;
    word_t     round_a;
    word_t     round_e;
    word_t     a_next;
    word_t     e_next;
    word_t     w_next;
    word_t     a_start_next;
    word_t     e_start_next;
    logic      start_push;
    logic      win_push;

    // Handshake: the input register moves on whenever the result slot frees.
    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.a_new = a_out_reg;
    assign out_ch.e_new = e_out_reg;
    assign out_ch.w_new = w_out_reg;

    // Schedule word for mix rounds.
    s256re_sched u_sched (
        .w_tm2  (w_window_reg[1]),
        .w_tm7  (w_window_reg[6]),
        .w_tm15 (w_window_reg[14]),
        .w_tm16 (w_window_reg[15]),
        .w_out  (sched_w)
    );

    assign round_w = (req_reg == REQ_LOAD) ? word_a_reg : sched_w;

    // Round function for load and mix rounds.
    s256re_round u_round (
        .a_chain (a_chain_reg),
        .e_chain (e_chain_reg),
        .w_in    (round_w),
        .k_in    (k_reg),
        .a_out   (round_a),
        .e_out   (round_e)
    );

    // Select the new words by request type.
    always_comb
    begin
        a_next       = round_a;
        e_next       = round_e;
        w_next       = round_w;
        a_start_next = a_start_reg[CHAIN_DEPTH-1];
        e_start_next = e_start_reg[CHAIN_DEPTH-1];
        start_push   = 1'b0;
        win_push     = 1'b0;
        case (req_reg)
            REQ_INIT:
            begin
                a_next       = cont_reg ? a_chain_reg[CHAIN_DEPTH-1] : word_a_reg;
                e_next       = cont_reg ? e_chain_reg[CHAIN_DEPTH-1] : word_e_reg;
                w_next       = '0;
                a_start_next = a_next;
                e_start_next = e_next;
                start_push   = 1'b1;
            end
            REQ_FINISH:
            begin
                a_next     = a_chain_reg[CHAIN_DEPTH-1] + a_start_reg[CHAIN_DEPTH-1];
                e_next     = e_chain_reg[CHAIN_DEPTH-1] + e_start_reg[CHAIN_DEPTH-1];
                w_next     = '0;
                start_push = 1'b1;
            end
            REQ_LOAD, REQ_MIX:
            begin
                win_push = 1'b1;
            end
            default:
            begin
                win_push = 1'b0;
            end
        endcase
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            req_reg    <= in_ch.req_type;
            word_a_reg <= in_ch.word_a;
            word_e_reg <= in_ch.word_e;
            k_reg      <= in_ch.round_const;
            cont_reg   <= in_ch.continue_chain;
        end
    end

    // Working chains and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_chain_reg   <= '0;
            e_chain_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                a_chain_reg   <= {a_chain_reg[CHAIN_DEPTH-2:0], a_next};
                e_chain_reg   <= {e_chain_reg[CHAIN_DEPTH-2:0], e_next};
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Start words, schedule window and result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_out_reg <= a_next;
            e_out_reg <= e_next;
            w_out_reg <= w_next;
            if (start_push)
            begin
                a_start_reg <= {a_start_reg[CHAIN_DEPTH-2:0], a_start_next};
                e_start_reg <= {e_start_reg[CHAIN_DEPTH-2:0], e_start_next};
            end
            if (win_push)
            begin
                w_window_reg <= {w_window_reg[WIN_DEPTH-2:0], w_next};
            end
        end
    end

    // A request that leaves the input register always produces a result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_ch.valid)
        else $error("result beat missing after advance");

    // The newest chain words match the result beat just produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (a_chain_reg[0] == out_ch.a_new) && (e_chain_reg[0] == out_ch.e_new))
        else $error("chain head differs from result beat");

    // Init and finish beats carry no schedule word.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (req_reg == REQ_INIT || req_reg == REQ_FINISH) |=> out_ch.w_new == '0)
        else $error("nonzero schedule word on init or finish");

    // A held request stays in the input register until it advances.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(req_reg))
        else $error("held request lost");

    // The window only moves on round requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && win_push) |=> $stable(w_window_reg))
        else $error("schedule window moved without a round");

endmodule

[hdl/s256re_sched.sv]
// ----------------------------------------------------------------------------
// SHA-256 message schedule word
// Derives W[t] from W[t-2], W[t-7], W[t-15] and W[t-16].
// ----------------------------------------------------------------------------
module s256re_sched
    import s256re_pkg::*;
(
    input  word_t w_tm2,
    input  word_t w_tm7,
    input  word_t w_tm15,
    input  word_t w_tm16,
    output word_t w_out
);

    // Four-term sum of the window words and their sigma transforms.
    assign w_out = w_tm16 + small_sigma0(w_tm15) + w_tm7 + small_sigma1(w_tm2);

endmodule

[hdl/s256re_round.sv]
// ----------------------------------------------------------------------------
// SHA-256 compression round
// Computes the new a and e words from the working chains, W and K.
// ----------------------------------------------------------------------------
module s256re_round
    import s256re_pkg::*;
(
    input  chain_t a_chain,
    input  chain_t e_chain,
    input  word_t  w_in,
    input  word_t  k_in,
    output word_t  a_out,
    output word_t  e_out
);

    word_t ch_val;
    word_t maj_val;
    word_t t1;

    // Choice and majority over the working words.
    assign ch_val  = (e_chain[0] & e_chain[1]) ^ (~e_chain[0] & e_chain[2]);
    assign maj_val = (a_chain[0] & a_chain[1]) ^ (a_chain[0] & a_chain[2])
                   ^ (a_chain[1] & a_chain[2]);

    // Temporary sum shared by both new words.
    assign t1 = w_in + k_in + e_chain[3] + ch_val + big_sigma1(e_chain[0]);

    assign a_out = t1 + maj_val + big_sigma0(a_chain[0]);
    assign e_out = t1 + a_chain[3];

endmodule

[bench/sha256_round_engine_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 round engine testbench
// Drives init, load, mix and finish beats into the engine. Mostly whole hash
// blocks with random words and some loose beats. A scoreboard predicts the
// a, e and schedule words of every beat and checks each result in order.
// ----------------------------------------------------------------------------
module sha256_round_engine_top_test
    import s256re_pkg::*;
();

    // One request beat as the sender offers it.
    typedef struct {
        req_type_t kind;
        word_t     word_a;
        word_t     word_e;
        word_t     round_const;
        logic      cont;
    } req_beat_t;

    // The three words that one request produces.
    typedef struct {
        word_t a_new;
        word_t e_new;
        word_t w_new;
    } round_words_t;

    // Tracks the engine state and holds the round words still to arrive.
    class round_scoreboard;
        word_t        a_chain[CHAIN_DEPTH];
        word_t        e_chain[CHAIN_DEPTH];
        word_t        a_saved[CHAIN_DEPTH];
        word_t        e_saved[CHAIN_DEPTH];
        word_t        sched[WIN_DEPTH];
        round_words_t expected_words_q[$];
        int           errors;

        function new();
            foreach (a_chain[i]) a_chain[i] = '0;
            foreach (e_chain[i]) e_chain[i] = '0;
            foreach (a_saved[i]) a_saved[i] = '0;
            foreach (e_saved[i]) e_saved[i] = '0;
            foreach (sched[i]) sched[i] = '0;
            errors = 0;
        endfunction

        function word_t ror(word_t x, int n);
            return (x >> n) | (x << (WORD_W - n));
        endfunction

        // Shift a word in at the newest end of a four-deep chain.
        function void push_chain(ref word_t v[CHAIN_DEPTH], input word_t x);
            for (int i = CHAIN_DEPTH - 1; i > 0; i--)
                v[i] = v[i-1];
            v[0] = x;
        endfunction

        function int outstanding();
            return expected_words_q.size();
        endfunction

        // Advance the predicted state by one accepted request beat.
        task note_request(req_beat_t b);
            round_words_t r;
            word_t        na, ne, nw, sa, se, x15, x2, s0, s1;
            word_t        sum0, sum1, choose, major, t1;
            nw = '0;
            case (b.kind)
                REQ_INIT:
                begin
                    na = b.cont ? a_chain[3] : b.word_a;
                    ne = b.cont ? e_chain[3] : b.word_e;
                    push_chain(a_saved, na);
                    push_chain(e_saved, ne);
                end
                REQ_FINISH:
                begin
                    // The oldest saved start word is used and rotated back in.
                    sa = a_saved[3];
                    se = e_saved[3];
                    na = a_chain[3] + sa;
                    ne = e_chain[3] + se;
                    push_chain(a_saved, sa);
                    push_chain(e_saved, se);
                end
                default:
                begin
                    if (b.kind == REQ_LOAD)
                        nw = b.word_a;
                    else
                    begin
                        x15 = sched[14];
                        x2  = sched[1];
                        s0  = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
                        s1  = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
                        nw  = sched[15] + s0 + sched[6] + s1;
                    end
                    for (int i = WIN_DEPTH - 1; i > 0; i--)
                        sched[i] = sched[i-1];
                    sched[0] = nw;

                    // Standard compression round on a..d and e..h.
                    sum0   = ror(a_chain[0], 2) ^ ror(a_chain[0], 13) ^ ror(a_chain[0], 22);
                    sum1   = ror(e_chain[0], 6) ^ ror(e_chain[0], 11) ^ ror(e_chain[0], 25);
                    choose = (e_chain[0] & e_chain[1]) ^ (~e_chain[0] & e_chain[2]);
                    major  = (a_chain[0] & a_chain[1]) ^ (a_chain[0] & a_chain[2])
                           ^ (a_chain[1] & a_chain[2]);
                    t1     = nw + b.round_const + e_chain[3] + choose + sum1;
                    na     = t1 + major + sum0;
                    ne     = t1 + a_chain[3];
                end
            endcase
            push_chain(a_chain, na);
            push_chain(e_chain, ne);
            r.a_new = na;
            r.e_new = ne;
            r.w_new = nw;
            expected_words_q.push_back(r);
        endtask

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        // Compare one result beat with the oldest expected words.
        task check_result(word_t a_new, word_t e_new, word_t w_new);
            round_words_t r;
            if (expected_words_q.size() == 0)
            begin
                report_mismatch("result beat with nothing expected");
                return;
            end
            r = expected_words_q.pop_front();
            if (a_new !== r.a_new)
                report_mismatch($sformatf("a_new %h, expected %h", a_new, r.a_new));
            if (e_new !== r.e_new)
                report_mismatch($sformatf("e_new %h, expected %h", e_new, r.e_new));
            if (w_new !== r.w_new)
                report_mismatch($sformatf("w_new %h, expected %h", w_new, r.w_new));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    s256re_in_if  in_ch();
    s256re_out_if out_ch();

    sha256_round_engine_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    round_scoreboard sb = new();

    int send_idle_pct = 9;
    int recv_idle_pct = 64;
    int inits_seen    = 0;
    int rounds_seen   = 0;
    int beats_sent    = 0;
    bit park_request  = 1'b0;

    // Free-running clock, 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Give up long after the slowest correct run would have ended.
    initial
    begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: check accepted beats, then pick the next ready level.
    initial
    begin
        int park_left;
        bit park_done;
        park_left = 0;
        park_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.a_new, out_ch.e_new, out_ch.w_new);
            if (park_left > 0)
            begin
                park_left--;
                out_ch.ready <= 1'b0;
            end
            else if (park_request && !park_done)
            begin
                // Hold the result side off long enough for the engine to fill.
                park_done = 1'b1;
                park_left = 60;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic req_beat_t make_beat(req_type_t kind, word_t wa, word_t we,
                                            word_t k, logic cont);
        req_beat_t b;
        b.kind        = kind;
        b.word_a      = wa;
        b.word_e      = we;
        b.round_const = k;
        b.cont        = cont;
        return b;
    endfunction

    function automatic req_beat_t random_beat(req_type_t kind);
        return make_beat(kind, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
    endfunction

    // Offer one beat, idling at random first, and wait for it to be taken.
    task automatic send_beat(req_beat_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.req_type       <= b.kind;
        in_ch.word_a         <= b.word_a;
        in_ch.word_e         <= b.word_e;
        in_ch.round_const    <= b.round_const;
        in_ch.continue_chain <= b.cont;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_request(b);
        beats_sent++;
        if (b.kind == REQ_INIT && inits_seen < CHAIN_DEPTH)
            inits_seen++;
        if ((b.kind == REQ_LOAD || b.kind == REQ_MIX) && rounds_seen < WIN_DEPTH)
            rounds_seen++;
    endtask

    // Stop offering beats until every expected result has come back.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() > 0)
            @(posedge clk);
    endtask

    // A whole hash block: four inits, sixteen loads, some mixes, four finishes.
    task automatic hash_block();
        req_beat_t b;
        logic      chain_on;
        int        n_mix;
        chain_on = 1'($urandom_range(1));
        n_mix    = $urandom_range(48, 1);
        repeat (CHAIN_DEPTH)
        begin
            b = random_beat(REQ_INIT);
            b.cont = chain_on;
            send_beat(b);
        end
        repeat (WIN_DEPTH) send_beat(random_beat(REQ_LOAD));
        repeat (n_mix) send_beat(random_beat(REQ_MIX));
        repeat (CHAIN_DEPTH) send_beat(random_beat(REQ_FINISH));
    endtask

    // Loose beats of any kind whose saved words have all been written.
    task automatic loose_beats(int count);
        req_type_t kind;
        repeat (count)
        begin
            do
                kind = req_type_t'($urandom_range(3));
            while ((kind == REQ_FINISH && inits_seen < CHAIN_DEPTH) ||
                   (kind == REQ_MIX && rounds_seen < WIN_DEPTH));
            send_beat(random_beat(kind));
        end
    endtask

    task automatic random_phase(int count);
        int target;
        target = beats_sent + count;
        while (beats_sent < target)
        begin
            if ($urandom_range(3) != 0)
                hash_block();
            else
                loose_beats($urandom_range(20, 5));
        end
    endtask

    // Main sequence: reset, directed beats, then three random phases.
    initial
    begin
        word_t ones;
        word_t wa;
        word_t k;
        ones = '1;
        in_ch.valid          <= 1'b0;
        in_ch.req_type       <= REQ_INIT;
        in_ch.word_a         <= '0;
        in_ch.word_e         <= '0;
        in_ch.round_const    <= '0;
        in_ch.continue_chain <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Inits: chaining from the zero chain, then extreme start words.
        send_beat(make_beat(REQ_INIT, ones, ones, ones, 1'b1));
        send_beat(make_beat(REQ_INIT, ones, ones, ones, 1'b0));
        send_beat(make_beat(REQ_INIT, '0, '0, '0, 1'b0));
        send_beat(make_beat(REQ_INIT, 32'h8000_0000, 32'h0000_0001, $urandom, 1'b0));

        // Loads fill the schedule window, with extreme words and constants.
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            wa = (i == 0) ? ones : (i == 1) ? '0 : (i == 2) ? 32'h8000_0000 :
                 (i == 3) ? 32'h0000_0001 : word_t'($urandom);
            k  = (i == 0) ? '0 : (i == 1) ? ones : word_t'($urandom);
            send_beat(make_beat(REQ_LOAD, wa, $urandom, k, 1'($urandom_range(1))));
        end

        // Mixes with the ignored message word at both extremes.
        send_beat(make_beat(REQ_MIX, ones, ones, ones, 1'b1));
        send_beat(make_beat(REQ_MIX, '0, '0, '0, 1'b0));

        // Finishes pair up with the four inits above.
        send_beat(make_beat(REQ_FINISH, ones, ones, ones, 1'b1));
        send_beat(make_beat(REQ_FINISH, '0, '0, '0, 1'b0));
        send_beat(make_beat(REQ_FINISH, ones, '0, ones, 1'b1));
        send_beat(make_beat(REQ_FINISH, '0, ones, '0, 1'b0));

        random_phase(120);
        wait_drained();

        send_idle_pct = 64;
        recv_idle_pct = 9;
        random_phase(120);
        wait_drained();

        // No idling; the result side is parked once so the input stalls.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        park_request <= 1'b1;
        random_phase(120);

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
hdl/s256re_pkg.sv
hdl/s256re_in_if.sv
hdl/s256re_out_if.sv
hdl/s256re_sched.sv
hdl/s256re_round.sv
hdl/sha256_round_engine_top.sv
bench/sha256_round_engine_top_test.sv
